FILE: rtl/core/spbf_pkg.sv
// Shared types and constants of the segment versus polygon test.
// Holds coordinate widths, request and result structs and register codes.
// Depends on nothing; every other file imports it.
package spbf_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned PROD_W     = 2 * DIFF_W;
  localparam int unsigned CROSS_W    = PROD_W + 1;
  localparam int unsigned THR_W      = 34;
  localparam int unsigned CMP_W      = (CROSS_W > THR_W) ? CROSS_W : THR_W;

  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QAW        = $clog2(QDEPTH);

  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 64;
  localparam int unsigned REG_SEL_BIT = 3;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_SKIP      = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [1:0] {
    RES_MISS   = 2'd0,
    RES_INSIDE = 2'd1,
    RES_HIT    = 2'd2
  } res_code_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;
  } in_req_t;

  typedef struct packed {
    res_code_e result_code;
    logic      start_inside;
    logic      end_inside;
    logic      edge_hit;
  } out_rsp_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic new_poly;
    logic last;
  } job_ctl_t;

  typedef struct packed {
    point_t   seg_start;
    point_t   seg_end;
    point_t   prev;
    point_t   vert;
    point_t   first;
    job_ctl_t ctl;
  } edge_job_t;

  typedef struct packed {
    logic start_tgl;
    logic end_tgl;
    logic hit;
  } edge_bits_t;

endpackage

FILE: rtl/core/spbf_front.sv
// Front end: accepts vertex requests and forms the edge jobs of each vertex.
// Keeps the query segment, first vertex and previous vertex of the polygon.
// Depends on spbf_pkg.
module spbf_front import spbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_req_t   in_req_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      full_i,
  output logic      push_o,
  output edge_job_t job_o
);

  logic   within_q;
  point_t seg_s_q, seg_e_q, first_q, prev_q;
  point_t in_s, in_e, in_v;
  logic   new_poly;

  assign in_s = '{x: in_req_i.seg_start_x, y: in_req_i.seg_start_y};
  assign in_e = '{x: in_req_i.seg_end_x, y: in_req_i.seg_end_y};
  assign in_v = '{x: in_req_i.vertex_x, y: in_req_i.vertex_y};

  assign new_poly   = !within_q;
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    job_o.seg_start    = new_poly ? in_s : seg_s_q;
    job_o.seg_end      = new_poly ? in_e : seg_e_q;
    job_o.prev         = prev_q;
    job_o.vert         = in_v;
    job_o.first        = new_poly ? in_v : first_q;
    job_o.ctl.new_poly = new_poly;
    job_o.ctl.last     = in_req_i.last_vertex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      within_q <= 1'b0;
    end else if (push_o) begin
      within_q <= !in_req_i.last_vertex;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o) begin
      prev_q <= in_v;
      if (new_poly) begin
        seg_s_q <= in_s;
        seg_e_q <= in_e;
        first_q <= in_v;
      end
    end
  end

endmodule

FILE: rtl/core/spbf_queue.sv
// Short queue of edge jobs between the front end and the back end.
// Register-based ring with a fill count; depth set in spbf_pkg.
// Depends on spbf_pkg.
module spbf_queue import spbf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  edge_job_t job_i,
  output logic      full_o,
  input  logic      pop_i,
  output edge_job_t job_o,
  output logic      valid_o
);

  edge_job_t        mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     count_q;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/core/spbf_edge_lane.sv
// One edge of the polygon against the query segment, in two register stages.
// Stage one forms the exact products, stage two the crossing and hit tests.
// Depends on spbf_pkg.
module spbf_edge_lane import spbf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  point_t           a_i,
  input  point_t           b_i,
  input  point_t           s_i,
  input  point_t           e_i,
  input  logic [THR_W-1:0] thr_i,
  output edge_bits_t       bits_o
);

  logic signed [DIFF_W-1:0]  d0x, d0y, d1x, d1y, dx, dy, ex, ey;
  logic signed [PROD_W-1:0]  f0_q, f1_q, m10_q, m11_q, m20_q, m21_q, e0_q, e1_q;
  logic                      fas_q, fbs_q, fae_q, fbe_q;
  logic signed [CROSS_W-1:0] f, m1, m2, ve;
  logic [CROSS_W-1:0]        mag;
  logic                      pos, span1, span2, m2_pos, ve_pos;

  assign d0x = $signed(b_i.x) - $signed(a_i.x);
  assign d0y = $signed(b_i.y) - $signed(a_i.y);
  assign d1x = $signed(e_i.x) - $signed(s_i.x);
  assign d1y = $signed(e_i.y) - $signed(s_i.y);
  assign dx  = $signed(s_i.x) - $signed(a_i.x);
  assign dy  = $signed(s_i.y) - $signed(a_i.y);
  assign ex  = $signed(e_i.x) - $signed(a_i.x);
  assign ey  = $signed(e_i.y) - $signed(a_i.y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f0_q  <= d0x * d1y;
      f1_q  <= d0y * d1x;
      m10_q <= dx * d1y;
      m11_q <= dy * d1x;
      m20_q <= dx * d0y;
      m21_q <= dy * d0x;
      e0_q  <= ex * d0y;
      e1_q  <= ey * d0x;
      fas_q <= $signed(a_i.y) >= $signed(s_i.y);
      fbs_q <= $signed(b_i.y) >= $signed(s_i.y);
      fae_q <= $signed(a_i.y) >= $signed(e_i.y);
      fbe_q <= $signed(b_i.y) >= $signed(e_i.y);
    end
  end

  assign f   = f0_q - f1_q;
  assign m1  = m10_q - m11_q;
  assign m2  = m20_q - m21_q;
  assign ve  = e0_q - e1_q;
  assign mag = f[CROSS_W-1] ? -f : f;
  assign pos = !f[CROSS_W-1] && (f != '0);

  assign span1 = pos ? (!m1[CROSS_W-1] && (m1 <= f))
                     : ((m1[CROSS_W-1] || (m1 == '0)) && (m1 >= f));
  assign span2 = pos ? (!m2[CROSS_W-1] && (m2 <= f))
                     : ((m2[CROSS_W-1] || (m2 == '0)) && (m2 >= f));

  assign m2_pos = !m2[CROSS_W-1] && (m2 != '0);
  assign ve_pos = !ve[CROSS_W-1] && (ve != '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bits_o.start_tgl <= (fas_q != fbs_q) && (fas_q == m2_pos);
      bits_o.end_tgl   <= (fae_q != fbe_q) && (fae_q == ve_pos);
      bits_o.hit       <= (CMP_W'(mag) >= CMP_W'(thr_i)) && span1 && span2;
    end
  end

endmodule

FILE: rtl/core/spbf_back.sv
// Back end: runs the edge jobs through both edge lanes and folds the results.
// Keeps the crossing parities and hit flag and holds the result register.
// Depends on spbf_pkg and spbf_edge_lane.
module spbf_back import spbf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edge_job_t        job_i,
  input  logic             job_valid_i,
  output logic             job_pop_o,
  input  logic [THR_W-1:0] thr_i,
  input  logic             skip_i,
  output out_rsp_t         out_rsp_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  logic       adv;
  logic       va_q, vb_q;
  job_ctl_t   ctl_a_q, ctl_b_q;
  edge_bits_t bits1, bits2;
  logic       spar_q, epar_q, hit_q;
  logic       spar_d, epar_d, hit_d;
  logic       use1, use2, in_poly;
  logic       out_valid_q;
  out_rsp_t   out_rsp_q;

  assign adv       = !out_valid_q || out_ready_i;
  assign job_pop_o = adv && job_valid_i;

  spbf_edge_lane u_lane_prev (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (job_i.prev),
    .b_i    (job_i.vert),
    .s_i    (job_i.seg_start),
    .e_i    (job_i.seg_end),
    .thr_i  (thr_i),
    .bits_o (bits1)
  );

  spbf_edge_lane u_lane_close (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (job_i.vert),
    .b_i    (job_i.first),
    .s_i    (job_i.seg_start),
    .e_i    (job_i.seg_end),
    .thr_i  (thr_i),
    .bits_o (bits2)
  );

  assign use1 = !ctl_b_q.new_poly;
  assign use2 = ctl_b_q.last;

  always_comb begin
    spar_d  = (ctl_b_q.new_poly ? 1'b0 : spar_q)
              ^ (use1 && bits1.start_tgl) ^ (use2 && bits2.start_tgl);
    epar_d  = (ctl_b_q.new_poly ? 1'b0 : epar_q)
              ^ (use1 && bits1.end_tgl) ^ (use2 && bits2.end_tgl);
    hit_d   = (ctl_b_q.new_poly ? 1'b0 : hit_q)
              || (use1 && bits1.hit) || (use2 && bits2.hit);
    in_poly = !skip_i && (spar_d || epar_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      spar_q      <= 1'b0;
      epar_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        va_q <= job_valid_i;
        vb_q <= va_q;
        if (vb_q) begin
          spar_q <= spar_d;
          epar_q <= epar_d;
          hit_q  <= hit_d;
        end
      end
      if (adv && vb_q && ctl_b_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_a_q <= job_i.ctl;
      ctl_b_q <= ctl_a_q;
    end
    if (adv && vb_q && ctl_b_q.last) begin
      out_rsp_q.result_code  <= in_poly ? RES_INSIDE : (hit_d ? RES_HIT : RES_MISS);
      out_rsp_q.start_inside <= spar_d;
      out_rsp_q.end_inside   <= epar_d;
      out_rsp_q.edge_hit     <= hit_d;
    end
  end

  assign out_rsp_o   = out_rsp_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/segment_polygon_brute_force_test.sv
// Top level of the segment versus closed polygon test.
// Holds the configuration registers and joins front end, queue and back end.
// Depends on spbf_pkg, spbf_front, spbf_queue and spbf_back.
//
// Usage: polygon vertices arrive one request per cycle on the in channel
// (valid/ready) while in_ready_o is high. The query segment is taken from
// the request that carries the first vertex of a polygon; last_vertex closes
// the polygon back to that first vertex. Only the closing request yields a
// result on the out channel. Throughput is one vertex per cycle while the
// queue is not full. A result follows the last accepted vertex through the
// edge queue, the product stage of both edge lanes and the compare stage;
// the fold into the parity and hit flags then loads the result register.
// When the receiver stalls, the result register holds and the back end waits;
// the four-entry queue keeps taking vertices until it fills, then in_ready_o
// drops. Reset empties the queue and pipeline, clears the polygon state and
// sets parallel_threshold to 1 and skip_inside_test to 0. The APB port has
// parallel_threshold at address 0 and skip_inside_test at address 8; pready
// is always high and writes are meant for idle periods only.
module segment_polygon_brute_force_test import spbf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  in_req_t            in_req_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output out_rsp_t           out_rsp_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [THR_W-1:0] thr_q;
  logic             skip_q;
  logic             cfg_wr;
  logic             q_full, q_push, q_pop, q_valid;
  edge_job_t        job_in, job_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      skip_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_THRESHOLD: thr_q  <= pwdata[THR_W-1:0];
        REG_SKIP:      skip_q <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_THRESHOLD: prdata = PDATA_W'(thr_q);
      REG_SKIP:      prdata = PDATA_W'(skip_q);
      default:       prdata = '0;
    endcase
  end

  spbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .full_i     (q_full),
    .push_o     (q_push),
    .job_o      (job_in)
  );

  spbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .valid_o (q_valid)
  );

  spbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .thr_i       (thr_q),
    .skip_i      (skip_q),
    .out_rsp_o   (out_rsp_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

FILE: rtl/core/spbf_checker.sv
// Port-level checks of the segment versus polygon test's result channel.
// Bound to the top level; depends on spbf_pkg.
module spbf_checker import spbf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input out_rsp_t out_rsp_o,
  input logic     out_valid_o,
  input logic     out_ready_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed or dropped while stalled");

  a_hit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.result_code == RES_HIT) |-> out_rsp_o.edge_hit)
    else $error("hit code without edge hit flag");

  a_inside_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.result_code == RES_INSIDE)
      |-> (out_rsp_o.start_inside || out_rsp_o.end_inside))
    else $error("inside code without an inside endpoint");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.result_code == RES_MISS) |-> !out_rsp_o.edge_hit)
    else $error("miss code with edge hit flag set");

endmodule

bind segment_polygon_brute_force_test spbf_checker u_spbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_rsp_o   (out_rsp_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);
